@@ hw/rtl/residue_contact_order_macros.svh @@
// assertion helpers for the contact order block
`ifndef RESIDUE_CONTACT_ORDER_MACROS_SVH
`define RESIDUE_CONTACT_ORDER_MACROS_SVH
`define RCO_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define RCO_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

@@ hw/rtl/rco_pkg.sv @@
// ----------------------------------------------------------------------------
// rco_pkg
// types and constants shared by the contact order block
// ----------------------------------------------------------------------------
`default_nettype none
package rco_pkg;
	localparam logic [23:0] DIST2_LOW  = 24'd4000000;
	localparam logic [23:0] DIST2_HIGH = 24'd12250000;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BREAK = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_BAD = 2'd3;
	localparam logic CFG_LOW = 1'b0;
	localparam logic CFG_HIGH = 1'b1;

	// one classified command passed from the front to the back
	typedef struct packed {
		logic               rd;
		logic               clr;
		logic               ld;
		logic               go;
		logic signed [14:0] res;
		logic signed [24:0] x;
		logic signed [24:0] y;
		logic signed [24:0] z;
		logic [7:0]         gidx;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE, B_CLR, B_GRP, B_GRPW, B_OUTER, B_OWAIT, B_INNER, B_IWAIT,
		B_DIST, B_ACC, B_ACCW, B_RD, B_RDW, B_DIV
	} bstate_t;
endpackage
`default_nettype wire

@@ hw/rtl/rco_ram.sv @@
// ----------------------------------------------------------------------------
// rco_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module rco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/rco_front.sv @@
// ----------------------------------------------------------------------------
// rco_front
// takes commands, tracks alpha carbon chain, queues work for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module rco_front #(
	parameter int MAX_ATOMS = 2048
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic signed [14:0] residue_number,
	input  wire logic signed [24:0] x_milli,
	input  wire logic signed [24:0] y_milli,
	input  wire logic signed [24:0] z_milli,
	input  wire logic               is_alpha_carbon,
	input  wire logic               last_atom,
	input  wire logic [7:0]         group_index,
	input  wire logic               back_ready,
	output rco_pkg::cmd_t           cmd,
	output logic                    cmd_valid,
	input  wire logic               cmd_pop,
	output logic                    chain_break
);
	import rco_pkg::*;
	localparam int AW = $clog2(MAX_ATOMS + 1);
	logic [AW-1:0] cnt_q;
	logic rdy_q, seen_q, brk_q, busy_q;
	logic signed [14:0] last_q;
	cmd_t fifo_q [2];
	logic wp_q, rp_q;
	logic [1:0] fill_q;
	logic acc, fresh, store;
	cmd_t c;

	assign acc = start && !busy;
	assign fresh = !operation && rdy_q;
	assign store = !operation && ((fresh ? AW'(0) : cnt_q) < AW'(MAX_ATOMS));
	// a last atom or a read must wait until the back end has drained
	assign busy = busy_q || fill_q == 2'd2 || !back_ready;
	assign chain_break = brk_q;
	assign cmd = fifo_q[rp_q];
	assign cmd_valid = fill_q != 2'd0;

	always_comb begin
		c.rd = operation;
		c.clr = fresh;
		c.ld = store;
		c.go = !operation && last_atom;
		c.res = residue_number;
		c.x = x_milli;
		c.y = y_milli;
		c.z = z_milli;
		c.gidx = group_index;
	end

	always_ff @(posedge clk) begin
		if (acc) fifo_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rdy_q <= 1'b0; seen_q <= 1'b0; brk_q <= 1'b0;
			last_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0; fill_q <= '0; busy_q <= 1'b0;
		end else begin
			busy_q <= acc && (operation || last_atom);
			if (acc) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, acc} - {1'b0, cmd_pop};
			if (acc && !operation) begin
				if (fresh) begin
					rdy_q <= 1'b0; seen_q <= 1'b0; brk_q <= 1'b0;
				end
				if (store) begin
					cnt_q <= (fresh ? AW'(0) : cnt_q) + AW'(1);
					if (is_alpha_carbon) begin
						if ((seen_q && !fresh) &&
							(32'(residue_number) != 32'(last_q) + 32'sd1))
							brk_q <= 1'b1;
						last_q <= residue_number;
						seen_q <= 1'b1;
					end
				end else if (fresh) begin
					cnt_q <= '0;
				end
				if (last_atom) rdy_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/rco_back.sv @@
// ----------------------------------------------------------------------------
// rco_back
// stores atoms, forms groups, runs the pair scan and answers reads
// ----------------------------------------------------------------------------
`default_nettype none
module rco_back #(
	parameter int MAX_ATOMS = 2048,
	parameter int MAX_GROUPS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rco_pkg::cmd_t      cmd,
	input  wire logic               cmd_valid,
	output logic                    cmd_pop,
	output logic                    idle,
	input  wire logic signed [14:0] win_lo,
	input  wire logic signed [14:0] win_hi,
	input  wire logic               chain_break,
	output logic                    done,
	output logic signed [14:0]      group_residue,
	output logic [31:0]             separation_sum,
	output logic [22:0]             contact_count,
	output logic [23:0]             contact_order_q10,
	output logic                    in_window,
	output logic [8:0]              group_total,
	output logic [1:0]              status
);
	import rco_pkg::*;
	localparam int AI = $clog2(MAX_ATOMS);
	localparam int AW = $clog2(MAX_ATOMS + 1);
	localparam int GI = $clog2(MAX_GROUPS);
	localparam int GW = $clog2(MAX_GROUPS + 1);

	bstate_t st_q, st_d;
	logic [AW-1:0] n_q, i_q, j_q;
	logic [GW-1:0] gcnt_q, g_q;
	logic ready_q;
	logic signed [14:0] ri_q, rprev_q;
	logic signed [24:0] xi_q, yi_q, zi_q;
	logic [GW-1:0] gi_q;
	logic [49:0] dx2_q, dy2_q, dz2_q;
	logic [15:0] sep_q;
	logic hit_q;
	logic [55:0] num_q;
	logic [22:0] den_q;
	logic [23:0] quo_q;
	logic [5:0] k_q;
	logic [7:0] ridx_q;

	// atom memory: residue, x, y, z, group index
	localparam int AWD = 15 + 75 + GW;
	logic a_we; logic [AI-1:0] a_wa, a_ra; logic [AWD-1:0] a_wd, a_rd;
	rco_ram #(.WIDTH(AWD), .DEPTH(MAX_ATOMS)) u_atom (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	logic signed [14:0] rd_r; logic signed [24:0] rd_x, rd_y, rd_z; logic [GW-1:0] rd_g;
	assign {rd_r, rd_x, rd_y, rd_z, rd_g} = a_rd;

	localparam int GWD = 15 + 32 + 23;
	logic g_we; logic [GI-1:0] g_wa, g_ra; logic [GWD-1:0] g_wd, g_rd;
	rco_ram #(.WIDTH(GWD), .DEPTH(MAX_GROUPS)) u_grp (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
	logic signed [14:0] gr_r; logic [31:0] gr_s; logic [22:0] gr_c;
	assign {gr_r, gr_s, gr_c} = g_rd;

	function automatic logic ins(input logic signed [14:0] r,
		input logic signed [14:0] lo, input logic signed [14:0] hi);
		return r > lo && r < hi;
	endfunction

	logic signed [25:0] ddx, ddy, ddz;
	logic [25:0] ax, ay, az;
	logic [51:0] d2;
	logic signed [15:0] dr;
	logic [32:0] sadd;
	logic [GW-1:0] g_nx;
	assign ddx = 26'(rd_x) - 26'(xi_q);
	assign ddy = 26'(rd_y) - 26'(yi_q);
	assign ddz = 26'(rd_z) - 26'(zi_q);
	assign ax = ddx[25] ? 26'(-ddx) : 26'(ddx);
	assign ay = ddy[25] ? 26'(-ddy) : 26'(ddy);
	assign az = ddz[25] ? 26'(-ddz) : 26'(ddz);
	assign d2 = 52'(dx2_q) + 52'(dy2_q) + 52'(dz2_q);
	assign dr = 16'(ri_q) - 16'(rd_r);
	assign sadd = 33'(gr_s) + 33'(sep_q);
	// group of the atom being grouped, a new residue opens the next group
	assign g_nx = (i_q != '0 && rd_r != rprev_q && g_q < GW'(MAX_GROUPS)) ?
		g_q + GW'(1) : g_q;

	logic ldv;
	logic [55:0] trial;
	assign trial = {num_q[54:0], 1'b0};

	always_comb begin
		st_d = st_q; cmd_pop = 1'b0; a_we = 1'b0; a_wa = i_q[AI-1:0];
		a_wd = {cmd.res, cmd.x, cmd.y, cmd.z, GW'(0)}; a_ra = i_q[AI-1:0];
		g_we = 1'b0; g_wa = g_q[GI-1:0]; g_wd = '0; g_ra = gi_q[GI-1:0];
		ldv = 1'b0;
		case (st_q)
			B_IDLE: if (cmd_valid) begin
				cmd_pop = 1'b1;
				if (cmd.rd) st_d = B_RD;
				else begin
					ldv = 1'b1;
					a_we = cmd.ld;
					a_wa = (cmd.clr ? AW'(0) : n_q) < AW'(MAX_ATOMS) ?
						AI'(cmd.clr ? AW'(0) : n_q) : '0;
					if (cmd.go) st_d = B_CLR;
				end
			end
			B_CLR: begin
				g_we = 1'b1; g_wd = '0;
				if (g_q == GW'(MAX_GROUPS - 1)) st_d = B_GRP;
			end
			B_GRP: st_d = (i_q == n_q) ? B_OUTER : B_GRPW;
			B_GRPW: begin
				// rewrite atom with its group number
				a_we = 1'b1; a_wa = i_q[AI-1:0];
				a_wd = {rd_r, rd_x, rd_y, rd_z, g_nx};
				if (g_nx < GW'(MAX_GROUPS)) begin
					g_we = 1'b1; g_wa = g_nx[GI-1:0]; g_wd = {rd_r, 32'd0, 23'd0};
				end
				st_d = B_GRP;
			end
			B_OUTER: st_d = (i_q == n_q) ? B_IDLE : B_OWAIT;
			B_OWAIT: st_d = (rd_g >= GW'(MAX_GROUPS) || !ins(rd_r, win_lo, win_hi)) ?
				B_OUTER : B_INNER;
			B_INNER: st_d = (j_q == n_q) ? B_OUTER : B_IWAIT;
			B_IWAIT: begin a_ra = j_q[AI-1:0]; st_d = B_DIST; end
			B_DIST: st_d = B_ACC;
			B_ACC: st_d = B_ACCW;
			B_ACCW: begin
				if (hit_q) begin
					g_we = 1'b1; g_wa = gi_q[GI-1:0];
					g_wd = {gr_r, sadd[32] ? 32'hFFFF_FFFF : sadd[31:0],
						gr_c == 23'h7FFFFF ? gr_c : gr_c + 23'd1};
				end
				st_d = B_INNER;
			end
			B_RD: begin g_ra = GI'(ridx_q); st_d = B_RDW; end
			B_RDW: begin g_ra = GI'(ridx_q); st_d = B_DIV; end
			B_DIV: begin g_ra = GI'(ridx_q); if (k_q == 6'd0) st_d = B_IDLE; end
			default: st_d = B_IDLE;
		endcase
		if (st_q == B_GRP || st_q == B_GRPW) a_ra = i_q[AI-1:0];
		if (st_q == B_OUTER || st_q == B_OWAIT) a_ra = i_q[AI-1:0];
		if (st_q == B_INNER) a_ra = j_q[AI-1:0];
	end

	assign idle = st_q == B_IDLE;
	assign group_total = 9'(gcnt_q);

	always_ff @(posedge clk) begin
		case (st_q)
			B_OWAIT: begin ri_q <= rd_r; xi_q <= rd_x; yi_q <= rd_y; zi_q <= rd_z;
				gi_q <= rd_g; end
			B_IWAIT: ;
			B_DIST: begin
				dx2_q <= 50'(ax) * 50'(ax); dy2_q <= 50'(ay) * 50'(ay);
				dz2_q <= 50'(az) * 50'(az);
				sep_q <= dr[15] ? 16'(-dr) : 16'(dr);
				hit_q <= rd_r != ri_q && ins(rd_r, win_lo, win_hi);
			end
			B_ACC: hit_q <= hit_q && d2 > 52'(DIST2_LOW) && d2 <= 52'(DIST2_HIGH);
			default: ;
		endcase
		if (st_q == B_IDLE) ridx_q <= cmd.gidx;
		if (st_q == B_RDW) begin
			num_q <= {24'd0, g_rd[54:23]}; den_q <= gr_c; quo_q <= '0; k_q <= 6'd42;
		end else if (st_q == B_DIV) begin
			// restoring divide of sum*1024 by count, one bit per cycle
			k_q <= k_q - 6'd1;
			if (k_q > 6'd32) num_q <= trial;
			else if (trial[55:32] >= 24'(den_q)) begin
				num_q <= {trial[55:32] - 24'(den_q), trial[31:0]};
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				num_q <= trial; quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	logic ok;
	assign ok = ready_q && 32'(ridx_q) < 32'(gcnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE; n_q <= '0; i_q <= '0; j_q <= '0; gcnt_q <= '0; g_q <= '0;
			ready_q <= 1'b0; rprev_q <= '0; done <= 1'b0;
			group_residue <= '0; separation_sum <= '0; contact_count <= '0;
			contact_order_q10 <= '0; in_window <= 1'b0; status <= ST_OK;
		end else begin
			st_q <= st_d;
			done <= 1'b0;
			if (ldv) begin
				if (cmd.clr) begin n_q <= '0; gcnt_q <= '0; ready_q <= 1'b0; end
				if (cmd.ld) n_q <= (cmd.clr ? AW'(0) : n_q) + AW'(1);
				g_q <= '0;
			end
			case (st_q)
				B_CLR: begin
					g_q <= g_q + GW'(1);
					if (g_q == GW'(MAX_GROUPS - 1)) begin i_q <= '0; g_q <= '0; end
				end
				B_GRP: if (i_q == n_q) begin
					i_q <= '0; ready_q <= 1'b1;
					gcnt_q <= (n_q == '0) ? '0 :
						(g_q < GW'(MAX_GROUPS) ? g_q + GW'(1) : GW'(MAX_GROUPS));
				end
				B_GRPW: begin
					g_q <= g_nx;
					rprev_q <= rd_r;
					i_q <= i_q + AW'(1);
				end
				B_OWAIT: begin
					if (rd_g >= GW'(MAX_GROUPS) || !ins(rd_r, win_lo, win_hi))
						i_q <= i_q + AW'(1);
					j_q <= '0;
				end
				B_INNER: if (j_q == n_q) i_q <= i_q + AW'(1);
				B_ACCW: j_q <= j_q + AW'(1);
				B_DIV: if (k_q == 6'd0) begin
					done <= 1'b1;
					if (ok) begin
						group_residue <= gr_r; separation_sum <= gr_s;
						contact_count <= gr_c; in_window <= ins(gr_r, win_lo, win_hi);
						contact_order_q10 <= gr_c == '0 ? '0 : quo_q;
						status <= chain_break ? ST_BREAK : (gr_c == '0 ? ST_NONE : ST_OK);
					end else begin
						group_residue <= '0; separation_sum <= '0; contact_count <= '0;
						contact_order_q10 <= '0; in_window <= 1'b0; status <= ST_BAD;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/residue_contact_order.sv @@
// ----------------------------------------------------------------------------
// residue_contact_order
// per residue relative contact order engine
// ----------------------------------------------------------------------------
// Atom loads are taken back to back while busy stays low. The last atom starts
// a clearing pass over all MAX_GROUPS group entries, a grouping pass of B_GRP
// and B_GRPW per atom and a pair scan of B_INNER to B_ACCW for each in-window
// outer atom with every stored atom (through the one read port of the atom
// ram); busy is high for all of it. A read is answered by a one bit per cycle
// divider; the result shows for one cycle on done and cannot be held off.
`default_nettype none
`include "residue_contact_order_macros.svh"
module residue_contact_order #(
	parameter int MAX_ATOMS = 2048,
	parameter int MAX_GROUPS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic signed [14:0] residue_number,
	input  wire logic signed [24:0] x_milli,
	input  wire logic signed [24:0] y_milli,
	input  wire logic signed [24:0] z_milli,
	input  wire logic               is_alpha_carbon,
	input  wire logic               last_atom,
	input  wire logic [7:0]         group_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [14:0]        cfg_data,
	output logic                    done,
	output logic signed [14:0]      group_residue,
	output logic [31:0]             separation_sum,
	output logic [22:0]             contact_count,
	output logic [23:0]             contact_order_q10,
	output logic                    in_window,
	output logic [8:0]              group_total,
	output logic [1:0]              status
);
	import rco_pkg::*;
	logic signed [14:0] lo_q, hi_q;
	cmd_t cmd; logic cmd_valid, cmd_pop, idle, brk;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= 15'sd0; hi_q <= 15'sd9999;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_LOW) lo_q <= cfg_data;
			else hi_q <= cfg_data;
		end
	end

	rco_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
		.clk, .arst_n, .start, .busy, .operation, .residue_number, .x_milli,
		.y_milli, .z_milli, .is_alpha_carbon, .last_atom, .group_index,
		.back_ready(idle), .cmd, .cmd_valid, .cmd_pop, .chain_break(brk));

	rco_back #(.MAX_ATOMS(MAX_ATOMS), .MAX_GROUPS(MAX_GROUPS)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_pop, .idle, .win_lo(lo_q),
		.win_hi(hi_q), .chain_break(brk), .done, .group_residue, .separation_sum,
		.contact_count, .contact_order_q10, .in_window, .group_total, .status);

	`RCO_ASSERT_IMP(a_done_pulse, done, !done)
	`RCO_ASSERT(a_ratio_zero, !done || contact_count != '0 || contact_order_q10 == '0)
	`RCO_ASSERT(a_bad_clear, !done || status != ST_BAD || separation_sum == '0)
endmodule
`default_nettype wire
